// ===== hw/rtl/itirc_pkg.sv =====
// ----------------------------------------------------------------------------
// itirc_pkg: shared types and constants
// Request classes, result status codes and the control bundle between the
// back-end sequencer and the entry table.
// ----------------------------------------------------------------------------
package itirc_pkg;

	localparam int ID_W  = 32;
	localparam int TAG_W = 32;
	localparam int ST_W  = 3;

	// incoming mode codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LIST   = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_DUP      = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;
	localparam logic [ST_W-1:0] ST_LISTED   = 3'd5;

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_REMOVE,
		CMD_LIST
	} cmd_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [ID_W-1:0]  id;
		logic [TAG_W-1:0]        tag;
	} req_t;

	// back end -> table
	typedef struct packed {
		logic                    cmp;  // capture match vector against id
		logic                    ins;  // append id/tag at slot cnt
		logic                    rem;  // compact from first match onwards
		logic                    rot;  // rotate valid entries one place down
		logic signed [ID_W-1:0]  id;
		logic [TAG_W-1:0]        tag;
	} tbl_ctrl_t;

endpackage

// ===== hw/rtl/itirc_front.sv =====
// ----------------------------------------------------------------------------
// itirc_front: request intake
// Accepts requests, classifies the mode, drops the unused code and queues
// the rest in a two-entry FIFO towards the back end.
// ----------------------------------------------------------------------------
module itirc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            mode,
	input  logic signed [itirc_pkg::ID_W-1:0]     order_id,
	input  logic [itirc_pkg::TAG_W-1:0]           customer_tag,
	output logic                                  q_valid,
	input  logic                                  q_ready,
	output itirc_pkg::req_t                       q_req
);

	itirc_pkg::req_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;
	itirc_pkg::cmd_t cmd;
	logic            keep;
	logic            push;
	logic            pop;

	always_comb begin
		cmd  = itirc_pkg::CMD_INSERT;
		keep = 1'b1;
		unique case (mode)
			itirc_pkg::MODE_INSERT: cmd = itirc_pkg::CMD_INSERT;
			itirc_pkg::MODE_REMOVE: cmd = itirc_pkg::CMD_REMOVE;
			itirc_pkg::MODE_LIST:   cmd = itirc_pkg::CMD_LIST;
			itirc_pkg::MODE_NONE:   keep = 1'b0;
			default:                keep = 1'b0;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (fill_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_req    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{cmd: cmd, id: order_id, tag: customer_tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hw/rtl/itirc_table.sv =====
// ----------------------------------------------------------------------------
// itirc_table: entry cells
// One register cell per slot. Every cell compares its ID in parallel, and
// each cell loads only from the request, its upper neighbour or slot zero,
// so append, compaction and list rotation move all cells at once.
// ----------------------------------------------------------------------------
module itirc_table #(
	parameter int DEPTH = 64,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                                  clk,
	input  itirc_pkg::tbl_ctrl_t                  ctrl,
	input  logic [CNT_W-1:0]                      cnt,
	output logic                                  hit_any,
	output logic signed [itirc_pkg::ID_W-1:0]     head_id,
	output logic [itirc_pkg::TAG_W-1:0]           head_tag
);

	logic signed [itirc_pkg::ID_W-1:0] id_q  [DEPTH];
	logic [itirc_pkg::TAG_W-1:0]       tag_q [DEPTH];
	logic [DEPTH-1:0]                  hit;
	logic [DEPTH-1:0]                  match_s1;

	// match vector is held until the back end acts on it
	always_ff @(posedge clk) begin
		if (ctrl.cmp)
			match_s1 <= hit;
	end

	assign hit_any  = |match_s1;
	assign head_id  = id_q[0];
	assign head_tag = tag_q[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int NXT = (i + 1 < DEPTH) ? i + 1 : i;

		assign hit[i] = (id_q[i] == ctrl.id) && (CNT_W'(i) < cnt);

		always_ff @(posedge clk) begin
			priority if (ctrl.ins && (CNT_W'(i) == cnt)) begin
				id_q[i]  <= ctrl.id;
				tag_q[i] <= ctrl.tag;
			end else if (ctrl.rem && (|match_s1[i:0])) begin
				id_q[i]  <= id_q[NXT];
				tag_q[i] <= tag_q[NXT];
			end else if (ctrl.rot) begin
				// last valid slot wraps round to the head
				if (CNT_W'(i) + CNT_W'(1) == cnt) begin
					id_q[i]  <= id_q[0];
					tag_q[i] <= tag_q[0];
				end else begin
					id_q[i]  <= id_q[NXT];
					tag_q[i] <= tag_q[NXT];
				end
			end
		end
	end

endmodule

// ===== hw/rtl/itirc_back.sv =====
// ----------------------------------------------------------------------------
// itirc_back: request execution
// Pops a queued request, captures the table match vector, then applies the
// update and loads the result register. A list rotates the table once per
// emitted entry, leaving it in its original order at the end.
// ----------------------------------------------------------------------------
module itirc_back #(
	parameter int DEPTH = 64,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	output logic                                  q_ready,
	input  itirc_pkg::req_t                       q_req,
	output itirc_pkg::tbl_ctrl_t                  ctrl,
	output logic [CNT_W-1:0]                      cnt,
	input  logic                                  hit_any,
	input  logic signed [itirc_pkg::ID_W-1:0]     head_id,
	input  logic [itirc_pkg::TAG_W-1:0]           head_tag,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [itirc_pkg::ST_W-1:0]            status,
	output logic signed [itirc_pkg::ID_W-1:0]     entry_id,
	output logic [itirc_pkg::TAG_W-1:0]           entry_tag,
	output logic                                  last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LIST
	} state_t;

	state_t           state_q;
	itirc_pkg::req_t  req_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] list_idx_q;
	logic             load;
	logic             full;
	logic             empty;
	logic             list_end;

	assign load     = !out_valid || out_ready;
	assign full     = (cnt_q >= CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign list_end = (list_idx_q + CNT_W'(1) == cnt_q);
	assign q_ready  = (state_q == S_IDLE);
	assign cnt      = cnt_q;

	always_comb begin
		ctrl     = '0;
		ctrl.id  = (state_q == S_IDLE) ? q_req.id : req_q.id;
		ctrl.tag = req_q.tag;
		ctrl.cmp = (state_q == S_IDLE) && q_valid;
		if (state_q == S_EXEC && load) begin
			ctrl.ins = (req_q.cmd == itirc_pkg::CMD_INSERT) && !full && !hit_any;
			ctrl.rem = (req_q.cmd == itirc_pkg::CMD_REMOVE) && !empty && hit_any;
		end
		ctrl.rot = (state_q == S_LIST) && load;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid)
			req_q <= q_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			list_idx_q <= '0;
			out_valid  <= 1'b0;
			status     <= itirc_pkg::ST_DONE;
			entry_id   <= '0;
			entry_tag  <= '0;
			last       <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (load) begin
						entry_id  <= '0;
						entry_tag <= '0;
						last      <= 1'b1;
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
						unique case (req_q.cmd)
							itirc_pkg::CMD_INSERT: begin
								priority if (full) begin
									status <= itirc_pkg::ST_FULL;
								end else if (hit_any) begin
									status <= itirc_pkg::ST_DUP;
								end else begin
									status <= itirc_pkg::ST_DONE;
									cnt_q  <= cnt_q + CNT_W'(1);
								end
							end
							itirc_pkg::CMD_REMOVE: begin
								priority if (empty) begin
									status <= itirc_pkg::ST_EMPTY;
								end else if (!hit_any) begin
									status <= itirc_pkg::ST_NOTFOUND;
								end else begin
									status   <= itirc_pkg::ST_DONE;
									entry_id <= req_q.id;
									cnt_q    <= cnt_q - CNT_W'(1);
								end
							end
							itirc_pkg::CMD_LIST: begin
								if (empty) begin
									status <= itirc_pkg::ST_EMPTY;
								end else begin
									out_valid  <= 1'b0;
									list_idx_q <= '0;
									state_q    <= S_LIST;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LIST: begin
					if (load) begin
						status     <= itirc_pkg::ST_LISTED;
						entry_id   <= head_id;
						entry_tag  <= head_tag;
						last       <= list_end;
						out_valid  <= 1'b1;
						list_idx_q <= list_idx_q + CNT_W'(1);
						if (list_end)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/id_table_insert_remove_compact.sv =====
// Path: an accepted request is written into the queue, then its match vector
// is captured, then it executes and loads the result register when that
// register is free; a list gives its first entry in the cycle after executing.
// Throughput: the back end takes a new request only from idle; a list
// rotates the table one entry per cycle while the result is not stalled.
// Reset: arst_n clears the entry count, queue and result register; slot
// contents are left as they are and are only read below the entry count.
// ----------------------------------------------------------------------------
// id_table_insert_remove_compact: arrival-ordered ID table
// Front end queues classified requests, back end sequences them against a
// register-cell table that compares in parallel and compacts on remove.
// ----------------------------------------------------------------------------
module id_table_insert_remove_compact #(
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            mode,
	input  logic signed [itirc_pkg::ID_W-1:0]     order_id,
	input  logic [itirc_pkg::TAG_W-1:0]           customer_tag,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [itirc_pkg::ST_W-1:0]            status,
	output logic signed [itirc_pkg::ID_W-1:0]     entry_id,
	output logic [itirc_pkg::TAG_W-1:0]           entry_tag,
	output logic                                  last
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// front -> back queue head
	logic                                  q_valid;
	logic                                  q_ready;
	itirc_pkg::req_t                       q_req;

	// back <-> table
	itirc_pkg::tbl_ctrl_t                  ctrl;
	logic [CNT_W-1:0]                      cnt;
	logic                                  hit_any;
	logic signed [itirc_pkg::ID_W-1:0]     head_id;
	logic [itirc_pkg::TAG_W-1:0]           head_tag;

	// intake: unused mode is accepted and dropped here, so it never
	// produces a result
	itirc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.order_id     (order_id),
		.customer_tag (customer_tag),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_req        (q_req)
	);

	// sequencer: owns the entry count and the result register
	itirc_back #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_req     (q_req),
		.ctrl      (ctrl),
		.cnt       (cnt),
		.hit_any   (hit_any),
		.head_id   (head_id),
		.head_tag  (head_tag),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.entry_id  (entry_id),
		.entry_tag (entry_tag),
		.last      (last)
	);

	// storage: slot zero is the list read point
	itirc_table #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_table (
		.clk      (clk),
		.ctrl     (ctrl),
		.cnt      (cnt),
		.hit_any  (hit_any),
		.head_id  (head_id),
		.head_tag (head_tag)
	);

endmodule

// ===== hw/rtl/itirc_checker.sv =====
// ----------------------------------------------------------------------------
// itirc_checker: port-level checks
// Watches the result channel of the ID table for handshake and encoding
// slips.
// ----------------------------------------------------------------------------
module itirc_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [itirc_pkg::ST_W-1:0]            status,
	input  logic signed [itirc_pkg::ID_W-1:0]     entry_id,
	input  logic [itirc_pkg::TAG_W-1:0]           entry_tag,
	input  logic                                  last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_id)
			&& $stable(entry_tag) && $stable(last))
		else $error("result changed while stalled");

	// only listed entries may be non-final
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != itirc_pkg::ST_LISTED) |-> last)
		else $error("non-list result without last");

	// status results carry no tag
	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != itirc_pkg::ST_LISTED) |-> (entry_tag == '0))
		else $error("tag on status result");

	// empty report carries no id
	a_empty_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == itirc_pkg::ST_EMPTY) |-> (entry_id == '0))
		else $error("id on empty report");

endmodule

bind id_table_insert_remove_compact itirc_checker u_itirc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.entry_id  (entry_id),
	.entry_tag (entry_tag),
	.last      (last)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for id_table_insert_remove_compact
// Drives insert, remove, list and unused-mode requests, keeps its own copy of
// the entry table to work out every result, and checks each result against
// the oldest one still due. Idling and a long output hold-off push the queue.
// ----------------------------------------------------------------------------
module tb;

	localparam int TBL_DEPTH  = 64;
	localparam int CYCLE_CAP  = 1000000;
	localparam int END_SETTLE = 20;

	localparam logic signed [itirc_pkg::ID_W-1:0] ID_MIN = 32'sh8000_0000;
	localparam logic signed [itirc_pkg::ID_W-1:0] ID_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [itirc_pkg::ST_W-1:0]         status;
		logic signed [itirc_pkg::ID_W-1:0]  id;
		logic [itirc_pkg::TAG_W-1:0]        tag;
		logic                               last;
	} result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic [1:0]                         mode;
	logic signed [itirc_pkg::ID_W-1:0]  order_id;
	logic [itirc_pkg::TAG_W-1:0]        customer_tag;
	logic                               out_valid;
	logic                               out_ready;
	logic [itirc_pkg::ST_W-1:0]         status;
	logic signed [itirc_pkg::ID_W-1:0]  entry_id;
	logic [itirc_pkg::TAG_W-1:0]        entry_tag;
	logic                               last;

	// bench copy of the table, arrival order, index 0 oldest
	logic signed [itirc_pkg::ID_W-1:0]  tbl_ids[$];
	logic [itirc_pkg::TAG_W-1:0]        tbl_tags[$];
	// results worked out at acceptance, oldest first
	result_t                            due_results[$];

	int  idle_pct;    // chance per cycle that the sender holds back
	int  stall_pct;   // chance per cycle that the receiver stalls
	int  hold_left;   // cycles of forced out_ready low still to run
	int  fail_count;
	int  cycle_count;

	id_table_insert_remove_compact #(
		.DEPTH(TBL_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.order_id(order_id),
		.customer_tag(customer_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_id(entry_id),
		.entry_tag(entry_tag),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("id_table_insert_remove_compact test failed");
			$finish;
		end
	end

	// receiver: long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// result checker: sampled at the rising edge, before the block updates
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0d entry_id %0d", status, entry_id);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (entry_id !== want.id) begin
					$error("entry_id: expected %0d, got %0d", want.id, entry_id);
					fail_count++;
				end
				if (entry_tag !== want.tag) begin
					$error("entry_tag: expected %h, got %h", want.tag, entry_tag);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	// Work out the results of one accepted request and update the bench table.
	// Full is tested before duplicate; remove takes the first matching entry
	// and closes the gap; unused mode changes nothing and gives nothing.
	function automatic void apply_to_table(input logic [1:0] m,
			input logic signed [itirc_pkg::ID_W-1:0] id,
			input logic [itirc_pkg::TAG_W-1:0] tag);
		int hit;
		hit = -1;
		foreach (tbl_ids[i])
			if (hit < 0 && tbl_ids[i] == id)
				hit = i;
		case (m)
			itirc_pkg::MODE_INSERT: begin
				if (tbl_ids.size() >= TBL_DEPTH) begin
					due_results.push_back('{itirc_pkg::ST_FULL, '0, '0, 1'b1});
				end else if (hit >= 0) begin
					due_results.push_back('{itirc_pkg::ST_DUP, '0, '0, 1'b1});
				end else begin
					tbl_ids.push_back(id);
					tbl_tags.push_back(tag);
					due_results.push_back('{itirc_pkg::ST_DONE, '0, '0, 1'b1});
				end
			end
			itirc_pkg::MODE_REMOVE: begin
				if (tbl_ids.size() == 0) begin
					due_results.push_back('{itirc_pkg::ST_EMPTY, '0, '0, 1'b1});
				end else if (hit < 0) begin
					due_results.push_back('{itirc_pkg::ST_NOTFOUND, '0, '0, 1'b1});
				end else begin
					tbl_ids.delete(hit);
					tbl_tags.delete(hit);
					due_results.push_back('{itirc_pkg::ST_DONE, id, '0, 1'b1});
				end
			end
			itirc_pkg::MODE_LIST: begin
				if (tbl_ids.size() == 0)
					due_results.push_back('{itirc_pkg::ST_EMPTY, '0, '0, 1'b1});
				else
					foreach (tbl_ids[i])
						due_results.push_back('{itirc_pkg::ST_LISTED, tbl_ids[i],
							tbl_tags[i], i == tbl_ids.size() - 1});
			end
			default: ;
		endcase
	endfunction

	// Offer one request from a falling edge and hold it until accepted.
	// Valid is left high afterwards; the next call replaces the request or a pause lowers it.
	task automatic send_request(input logic [1:0] m,
			input logic signed [itirc_pkg::ID_W-1:0] id,
			input logic [itirc_pkg::TAG_W-1:0] tag);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		order_id     <= id;
		customer_tag <= tag;
		do
			@(posedge clk);
		while (!in_ready);
		apply_to_table(m, id, tag);
	endtask

	// Sender pauses until every result due has been seen.
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// Mostly IDs that hit the table, sit at the edges or lie near zero, so that
	// duplicates and successful removes come up often.
	function automatic logic signed [itirc_pkg::ID_W-1:0] pick_id();
		int sel;
		logic signed [itirc_pkg::ID_W-1:0] v;
		sel = $urandom_range(0, 9);
		if (sel < 4 && tbl_ids.size() > 0)
			return tbl_ids[$urandom_range(0, tbl_ids.size() - 1)];
		if (sel < 7) begin
			case ($urandom_range(0, 3))
				0: return ID_MIN;
				1: return ID_MAX;
				default: begin
					v = $urandom_range(0, 15);
					return v - 8;
				end
			endcase
		end
		v = $urandom;
		return v;
	endfunction

	// One random request; unused-mode noise is not counted.
	task automatic random_request(output bit counted);
		int r;
		logic [1:0] m;
		r = $urandom_range(0, 99);
		if (r < 45)
			m = itirc_pkg::MODE_INSERT;
		else if (r < 78)
			m = itirc_pkg::MODE_REMOVE;
		else if (r < 93)
			m = itirc_pkg::MODE_LIST;
		else
			m = itirc_pkg::MODE_NONE;
		counted = (m != itirc_pkg::MODE_NONE);
		send_request(m, (m == itirc_pkg::MODE_NONE) ? itirc_pkg::ID_W'($urandom) : pick_id(),
			$urandom);
	endtask

	task automatic test_empty_table();
		send_request(itirc_pkg::MODE_REMOVE, 32'sd5, '0);
		send_request(itirc_pkg::MODE_LIST, '0, '1);
	endtask

	// extreme IDs and tags, the -1 and 100 values, a duplicate, then a list
	task automatic test_field_extremes();
		send_request(itirc_pkg::MODE_INSERT, ID_MIN, 32'h0000_0000);
		send_request(itirc_pkg::MODE_INSERT, ID_MAX, 32'hffff_ffff);
		send_request(itirc_pkg::MODE_INSERT, 32'sd0, 32'ha5a5_a5a5);
		send_request(itirc_pkg::MODE_INSERT, -32'sd1, 32'h5a5a_5a5a);
		send_request(itirc_pkg::MODE_INSERT, 32'sd100, $urandom);
		send_request(itirc_pkg::MODE_INSERT, -32'sd1, 32'h1234_5678);
		send_request(itirc_pkg::MODE_LIST, '0, '0);
	endtask

	// removes at the middle, head and tail; absent ID; unused mode ignored
	task automatic test_remove_compaction();
		send_request(itirc_pkg::MODE_REMOVE, 32'sd7, '0);
		send_request(itirc_pkg::MODE_REMOVE, 32'sd0, '1);
		send_request(itirc_pkg::MODE_LIST, '0, '0);
		send_request(itirc_pkg::MODE_NONE, ID_MAX, '1);
		send_request(itirc_pkg::MODE_REMOVE, ID_MIN, '0);
		send_request(itirc_pkg::MODE_REMOVE, 32'sd100, '0);
		send_request(itirc_pkg::MODE_LIST, '0, '0);
	endtask

	// fill every slot, hit full with a new and with a present ID,
	// list all 64, then take a few out and list again
	task automatic test_fill_to_capacity();
		logic signed [itirc_pkg::ID_W-1:0] id;
		while (tbl_ids.size() < TBL_DEPTH) begin
			do
				id = pick_id();
			while (id inside {tbl_ids});
			send_request(itirc_pkg::MODE_INSERT, id, $urandom);
		end
		do
			id = itirc_pkg::ID_W'($urandom);
		while (id inside {tbl_ids});
		send_request(itirc_pkg::MODE_INSERT, id, $urandom);
		send_request(itirc_pkg::MODE_INSERT, tbl_ids[0], $urandom);
		send_request(itirc_pkg::MODE_LIST, '0, '0);
		repeat (4)
			send_request(itirc_pkg::MODE_REMOVE,
				tbl_ids[$urandom_range(0, tbl_ids.size() - 1)], '0);
		send_request(itirc_pkg::MODE_LIST, '0, '0);
	endtask

	// receiver stops for a long stretch while requests keep coming, so the
	// queue fills and in_ready drops; then the sender waits for the backlog
	task automatic test_backpressure();
		bit counted;
		idle_pct  = 0;
		stall_pct = 0;
		// take down the request just accepted before the next rising edge
		@(negedge clk);
		in_valid  <= 1'b0;
		hold_left = 300;
		repeat (40)
			random_request(counted);
		wait_results_drained();
	endtask

	task automatic test_random(input int n_req, input int idle, input int stall);
		bit counted;
		int n;
		idle_pct  = idle;
		stall_pct = stall;
		n = 0;
		while (n < n_req) begin
			random_request(counted);
			if (counted)
				n++;
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = itirc_pkg::MODE_INSERT;
		order_id     = '0;
		customer_tag = '0;
		out_ready    = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_left    = 0;
		fail_count   = 0;
		cycle_count  = 0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_field_extremes();
		test_remove_compaction();
		test_fill_to_capacity();
		test_backpressure();
		test_random(60, 0, 0);
		test_random(60, 57, 0);
		test_random(60, 0, 57);
		test_random(60, 31, 31);

		wait_results_drained();
		repeat (END_SETTLE)
			@(posedge clk);
		if (fail_count == 0)
			$display("id_table_insert_remove_compact test passed");
		else
			$display("id_table_insert_remove_compact test failed");
		$finish;
	end

endmodule
